>>> rtl/fbr_pkg.sv
// Package for the framebuffer refresh block: job and back-end state types,
// register indexes and reset values, default geometry and sizes. No dependencies.
`timescale 1ns / 1ps

package fbr_pkg;

    // Default panel geometry
    localparam int FB_WIDTH  = 128;
    localparam int FB_HEIGHT = 64;

    // Widest store address over the whole geometry range (256 x 32 pages)
    localparam int FB_ADDR_MAX_W = 13;

    // Command bytes ahead of the data of each page
    localparam int FB_CMD_SLOTS = 4;
    localparam int FB_SLOT_PAGE = 0;
    localparam int FB_SLOT_COLL = 1;
    localparam int FB_SLOT_COLH = 2;
    localparam int FB_SLOT_RMW  = 3;

    // Register indexes
    localparam logic [7:0] CFG_PAGE_CMD_BASE = 8'd0;
    localparam logic [7:0] CFG_COL_LOW_BASE  = 8'd1;
    localparam logic [7:0] CFG_COL_HIGH_BASE = 8'd2;
    localparam logic [7:0] CFG_RMW_CMD       = 8'd3;

    // Register reset values
    localparam logic [7:0] RST_PAGE_CMD_BASE = 8'd176;
    localparam logic [7:0] RST_COL_LOW_BASE  = 8'd0;
    localparam logic [7:0] RST_COL_HIGH_BASE = 8'd16;
    localparam logic [7:0] RST_RMW_CMD       = 8'd224;

    // Job queue between front and back (power of two)
    localparam int FB_QDEPTH = 2;
    localparam int FB_QPTR_W = $clog2(FB_QDEPTH);
    localparam int FB_QCNT_W = $clog2(FB_QDEPTH + 1);

    typedef enum logic [1:0] {
        JOB_PIXEL,
        JOB_CMD,
        JOB_DATA
    } t_job_kind;

    // One classified job; value is the command byte or the pixel mask
    typedef struct packed {
        t_job_kind                kind;
        logic [FB_ADDR_MAX_W-1:0] addr;
        logic [7:0]               value;
        logic                     on;
        logic                     last;
    } t_job;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ
    } t_back_state;

endpackage

>>> rtl/fbr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module fbr_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/fbr_front.sv
// Front end: accepts transactions, holds the registers and the refresh
// position, and turns each item into a job for the back end. Uses fbr_pkg.
`timescale 1ns / 1ps

module fbr_front import fbr_pkg::*; #(
    parameter int WIDTH  = FB_WIDTH,
    parameter int HEIGHT = FB_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // item channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_op,
    input  logic [7:0] i_px,
    input  logic [7:0] i_py,
    input  logic       i_pixel_on,
    // register writes
    input  logic       i_cfg_valid,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // back end and queue
    input  logic       i_clearing,
    input  logic       i_q_full,
    output logic       o_push,
    output t_job       o_job
);

    localparam int PAGES  = (HEIGHT + 7) / 8;
    localparam int SLOTS  = WIDTH + FB_CMD_SLOTS;
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int POS_W  = $clog2(SLOTS);
    localparam int AW     = FB_ADDR_MAX_W;

    logic [7:0]        r_page_base;
    logic [7:0]        r_col_low;
    logic [7:0]        r_col_high;
    logic [7:0]        r_rmw;
    logic [PAGE_W-1:0] r_page, n_page;
    logic [POS_W-1:0]  r_pos, n_pos;

    logic accept;
    logic in_range;
    t_job job;

    assign o_in_ready = !i_clearing && !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    // register writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_base <= RST_PAGE_CMD_BASE;
            r_col_low   <= RST_COL_LOW_BASE;
            r_col_high  <= RST_COL_HIGH_BASE;
            r_rmw       <= RST_RMW_CMD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PAGE_CMD_BASE: r_page_base <= i_cfg_data;
                CFG_COL_LOW_BASE:  r_col_low   <= i_cfg_data;
                CFG_COL_HIGH_BASE: r_col_high  <= i_cfg_data;
                CFG_RMW_CMD:       r_rmw       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // classify the item
    always_comb begin
        in_range   = ({1'b0, i_px} < 9'(WIDTH)) && ({1'b0, i_py} < 9'(HEIGHT));
        job        = '0;
        job.kind   = JOB_PIXEL;
        job.on     = i_pixel_on;
        if (!i_op) begin
            job.kind  = JOB_PIXEL;
            job.addr  = AW'(i_px) + AW'(i_py[7:3]) * AW'(WIDTH);
            job.value = 8'h80 >> i_py[2:0];
        end else if (r_pos == POS_W'(FB_SLOT_PAGE)) begin
            job.kind  = JOB_CMD;
            job.value = r_page_base | (8'(PAGES - 1) - 8'(r_page));
        end else if (r_pos == POS_W'(FB_SLOT_COLL)) begin
            job.kind  = JOB_CMD;
            job.value = r_col_low;
        end else if (r_pos == POS_W'(FB_SLOT_COLH)) begin
            job.kind  = JOB_CMD;
            job.value = r_col_high;
        end else if (r_pos == POS_W'(FB_SLOT_RMW)) begin
            job.kind  = JOB_CMD;
            job.value = r_rmw;
        end else begin
            job.kind  = JOB_DATA;
            job.addr  = AW'(r_page) * AW'(WIDTH) + AW'(r_pos) - AW'(FB_CMD_SLOTS);
            job.last  = (r_page == PAGE_W'(PAGES - 1)) && (r_pos == POS_W'(SLOTS - 1));
        end
    end

    // refresh position advances on each refresh step, wrapping per page and frame
    always_comb begin
        n_pos  = r_pos;
        n_page = r_page;
        if (accept && i_op) begin
            if (r_pos == POS_W'(SLOTS - 1)) begin
                n_pos  = '0;
                n_page = (r_page == PAGE_W'(PAGES - 1)) ? '0 : r_page + 1'b1;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_page <= '0;
        end else begin
            r_pos  <= n_pos;
            r_page <= n_page;
        end
    end

    // out-of-range pixel writes are taken and dropped
    assign o_push = accept && (i_op || in_range);
    assign o_job  = job;

endmodule

>>> rtl/fbr_queue.sv
// Short job FIFO between front and back ends, depth from the package.
// Uses fbr_pkg.
`timescale 1ns / 1ps

module fbr_queue import fbr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job                 r_mem [FB_QDEPTH];
    logic [FB_QPTR_W-1:0] r_wptr;
    logic [FB_QPTR_W-1:0] r_rptr;
    logic [FB_QCNT_W-1:0] r_count;

    assign o_full  = (r_count == FB_QCNT_W'(FB_QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // pointers wrap naturally, depth is a power of two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/fbr_back.sv
// Back end: clears the framebuffer after reset, then carries out jobs in
// order (pixel read-modify-write, stream reads, command bytes) and drives the output
// register. Uses fbr_pkg and fbr_ram.
`timescale 1ns / 1ps

module fbr_back import fbr_pkg::*; #(
    parameter int WIDTH  = FB_WIDTH,
    parameter int HEIGHT = FB_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // queue head
    input  t_job       i_job,
    input  logic       i_q_empty,
    output logic       o_pop,
    output logic       o_clearing,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_is_data,
    output logic       o_frame_last
);

    localparam int PAGES = (HEIGHT + 7) / 8;
    localparam int DEPTH = WIDTH * PAGES;
    localparam int AW    = $clog2(DEPTH);

    t_back_state r_state, n_state;
    logic [AW-1:0] r_clr_addr;
    t_job          r_job;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_data;
    logic          r_out_last;

    logic          out_free;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic          out_load;
    logic [7:0]    n_out_byte;
    logic          n_out_data;
    logic          n_out_last;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_clearing = (r_state == BK_CLEAR);

    fbr_ram #(
        .DW    (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!i_q_empty && i_job.kind != JOB_CMD) begin
                    n_state = BK_READ;
                end
            end
            BK_READ: begin
                if (r_job.kind == JOB_PIXEL || out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_job.addr[AW-1:0];
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = i_job.addr[AW-1:0];
        out_load   = 1'b0;
        n_out_byte = i_job.value;
        n_out_data = 1'b0;
        n_out_last = 1'b0;
        unique case (r_state)
            BK_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
            end
            BK_IDLE: begin
                if (!i_q_empty) begin
                    if (i_job.kind == JOB_CMD) begin
                        if (out_free) begin
                            o_pop    = 1'b1;
                            out_load = 1'b1;
                        end
                    end else begin
                        o_pop  = 1'b1;
                        ram_re = 1'b1;
                    end
                end
            end
            BK_READ: begin
                if (r_job.kind == JOB_PIXEL) begin
                    ram_we    = 1'b1;
                    ram_wdata = r_job.on ? (ram_rdata | r_job.value)
                                         : (ram_rdata & ~r_job.value);
                end else if (out_free) begin
                    out_load   = 1'b1;
                    n_out_byte = ram_rdata;
                    n_out_data = 1'b1;
                    n_out_last = r_job.last;
                end
            end
            default: ;
        endcase
    end

    // state, sweep counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (out_load) begin
            r_out_byte <= n_out_byte;
            r_out_data <= n_out_data;
            r_out_last <= n_out_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_is_data    = r_out_data;
    assign o_frame_last = r_out_last;

endmodule

>>> rtl/mono_lcd_framebuffer_refresh.sv
// Top level of the monochrome framebuffer with refresh stream.
// Uses fbr_pkg, fbr_front, fbr_queue and fbr_back.
//
// After reset the block sweeps the framebuffer to zero, one byte a cycle;
// o_in_ready is low for the sweep while register writes are taken
// throughout. The front end takes one transaction a cycle, while the queue
// is not full, into a two-entry job queue; the back end sets the sustained
// rate through the single framebuffer RAM: a command byte of the stream is
// loaded straight into the output register, while a data byte or a pixel
// write takes a registered RAM read, then an output load or write-back.
// Out-of-range pixel writes are taken and dropped. Results leave through
// an output register that a new item may queue behind.
`timescale 1ns / 1ps

module mono_lcd_framebuffer_refresh import fbr_pkg::*; #(
    parameter int WIDTH  = FB_WIDTH,
    parameter int HEIGHT = FB_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // item channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_op,
    input  logic [7:0] i_px,
    input  logic [7:0] i_py,
    input  logic       i_pixel_on,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_is_data,
    output logic       o_frame_last,
    // register writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic clearing;
    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_job front_job;
    t_job head_job;

    assign o_cfg_ready = 1'b1;

    fbr_front #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_px        (i_px),
        .i_py        (i_py),
        .i_pixel_on  (i_pixel_on),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_clearing  (clearing),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (front_job)
    );

    fbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty)
    );

    fbr_back #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (head_job),
        .i_q_empty    (q_empty),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_is_data    (o_is_data),
        .o_frame_last (o_frame_last)
    );

endmodule

>>> rtl/fbr_checker.sv
// Port-level checks for mono_lcd_framebuffer_refresh, bound to the top
// level below. No package dependency.
`timescale 1ns / 1ps

module fbr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_is_data,
    input logic       o_frame_last
);

    // a stalled result holds its valid and payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_is_data)
            && $stable(o_frame_last))
        else $error("result changed while stalled");

    // end of frame is flagged only on a data byte
    a_last_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_data |-> !o_frame_last)
        else $error("frame end flagged on a command byte");

    // the clearing sweep holds off items straight after reset
    a_clear_hold: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("item taken before the framebuffer sweep");

    // nothing comes out in the cycle after reset
    a_no_out_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown straight after reset");

endmodule

bind mono_lcd_framebuffer_refresh fbr_checker u_fbr_checker (.*);
